FILE: hw/rtl/dcrd_pkg.sv
// Shared types, constants and register codes of the distance code ring decoder.
package dcrd_pkg;

    localparam int unsigned RING_DEPTH = 4;
    localparam int unsigned SLOT_W     = $clog2(RING_DEPTH);
    localparam int unsigned DIST_W     = 32;
    localparam int unsigned CODE_W     = 10;
    localparam int unsigned EXTRA_W    = 24;
    localparam int unsigned BITS_W     = 5;
    localparam int unsigned DIRECT_W   = 7;
    localparam int unsigned POSTFIX_W  = 2;
    localparam int unsigned ADDR_W     = 4;

    localparam logic [DIRECT_W-1:0] MAX_DIRECT = 7'd120;

    // Ring contents after reset, oldest entry at index 0.
    localparam logic [RING_DEPTH-1:0][DIST_W-1:0] RING_INIT =
        {32'd16, 32'd15, 32'd11, 32'd4};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ADJ_NONE = 2'd0,
        ADJ_SUB  = 2'd1,
        ADJ_ADD  = 2'd2
    } adj_t;

    typedef enum logic {
        SRC_FIXED = 1'b0,
        SRC_RING  = 1'b1
    } src_t;

    typedef enum logic [1:0] {
        REG_SPECIAL_ENABLE = 2'd0,
        REG_DIRECT_COUNT   = 2'd1,
        REG_POSTFIX_BITS   = 2'd2
    } reg_index_t;

    // Everything about one request that does not depend on the ring.
    typedef struct packed {
        src_t              src;
        logic [SLOT_W-1:0] slot;
        adj_t              adj;
        logic [1:0]        amount;
        logic              push;
        logic [DIST_W-1:0] distance;
        logic [BITS_W-1:0] bits;
        status_t           status;
    } front_t;

endpackage

FILE: hw/rtl/dcrd_front.sv
// Ring-independent decode of a distance code: class, extra bit count, arithmetic distances.
module dcrd_front (
    input  logic                             special_enable,
    input  logic [dcrd_pkg::DIRECT_W-1:0]    direct_count,
    input  logic [dcrd_pkg::POSTFIX_W-1:0]   postfix_bits,
    input  logic                             operation,
    input  logic [dcrd_pkg::CODE_W-1:0]      distance_code,
    input  logic [dcrd_pkg::EXTRA_W-1:0]     extra_value,
    output dcrd_pkg::front_t                 front
);
    import dcrd_pkg::*;

    logic [10:0]       special_w;
    logic [10:0]       direct_end;
    logic [10:0]       limit;
    logic [10:0]       code_w;
    logic [10:0]       x;
    logic [10:0]       x_shr;
    logic              high_lsb;
    logic [2:0]        low_mask;
    logic [2:0]        low;
    logic [BITS_W-1:0] bits;
    logic [DIST_W-1:0] offset;
    logic [DIST_W-1:0] extra_w;
    logic [DIST_W-1:0] base_add;
    logic [DIST_W-1:0] brotli_dist;
    logic [DIST_W-1:0] deflate_dist;
    logic [DIST_W-1:0] direct_dist;
    logic [SLOT_W-1:0] slot;
    adj_t              adj;
    logic [1:0]        amount;

    // Code space boundaries for the current layout.
    always_comb
    begin
        special_w  = {6'd0, special_enable, 4'd0};
        direct_end = special_w + {4'd0, direct_count};
        limit      = direct_end + (11'd48 << postfix_bits);
        code_w     = {1'b0, distance_code};
    end

    // Postfix and offset arithmetic for codes past the direct range.
    always_comb
    begin
        x        = code_w - direct_end;
        x_shr    = x >> ({1'b0, postfix_bits} + 3'd1);
        bits     = 5'd1 + x_shr[BITS_W-1:0];
        high_lsb = x[postfix_bits];
        low_mask = 3'((4'd1 << postfix_bits) - 4'd1);
        low      = x[2:0] & low_mask;
        offset   = ({30'd0, 1'b1, high_lsb} << bits) - 32'd4;
        extra_w  = {8'd0, extra_value};
        base_add = {25'd0, direct_count} + 32'd1;
        brotli_dist  = ((offset + extra_w) << postfix_bits) + {29'd0, low} + base_add;
        deflate_dist = ((offset + {29'd0, low}) << postfix_bits) + extra_w + base_add;
        direct_dist  = {22'd0, distance_code} - {21'd0, special_w} + 32'd1;
    end

    // Ring slot and adjustment of the sixteen ring-reference codes.
    always_comb
    begin
        slot   = '0;
        adj    = ADJ_NONE;
        amount = 2'd0;
        case (distance_code[3:0])
            4'd1:  slot = 2'd1;
            4'd2:  slot = 2'd2;
            4'd3:  slot = 2'd3;
            4'd4:
            begin
                adj    = ADJ_SUB;
                amount = 2'd1;
            end
            4'd5:
            begin
                adj    = ADJ_ADD;
                amount = 2'd1;
            end
            4'd6:
            begin
                adj    = ADJ_SUB;
                amount = 2'd2;
            end
            4'd7:
            begin
                adj    = ADJ_ADD;
                amount = 2'd2;
            end
            4'd8:
            begin
                adj    = ADJ_SUB;
                amount = 2'd3;
            end
            4'd9:
            begin
                adj    = ADJ_ADD;
                amount = 2'd3;
            end
            4'd10:
            begin
                slot   = 2'd1;
                adj    = ADJ_SUB;
                amount = 2'd1;
            end
            4'd11:
            begin
                slot   = 2'd1;
                adj    = ADJ_ADD;
                amount = 2'd1;
            end
            4'd12:
            begin
                slot   = 2'd1;
                adj    = ADJ_SUB;
                amount = 2'd2;
            end
            4'd13:
            begin
                slot   = 2'd1;
                adj    = ADJ_ADD;
                amount = 2'd2;
            end
            4'd14:
            begin
                slot   = 2'd1;
                adj    = ADJ_SUB;
                amount = 2'd3;
            end
            4'd15:
            begin
                slot   = 2'd1;
                adj    = ADJ_ADD;
                amount = 2'd3;
            end
            default: slot = 2'd0;
        endcase
    end

    // Classify the code and pick the ring-independent result.
    always_comb
    begin
        front.src      = SRC_FIXED;
        front.slot     = '0;
        front.adj      = ADJ_NONE;
        front.amount   = 2'd0;
        front.push     = 1'b0;
        front.distance = '0;
        front.bits     = '0;
        front.status   = ST_OK;
        if (code_w >= limit)
        begin
            front.status = ST_RANGE;
        end
        else
        begin
            if (code_w >= direct_end)
            begin
                front.bits = bits;
            end
            if (operation)
            begin
                if (code_w < special_w)
                begin
                    front.src    = SRC_RING;
                    front.slot   = slot;
                    front.adj    = adj;
                    front.amount = amount;
                    front.push   = (distance_code != '0);
                end
                else if (code_w < direct_end)
                begin
                    front.distance = direct_dist;
                end
                else
                begin
                    front.distance = special_enable ? brotli_dist : deflate_dist;
                    front.push     = special_enable;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/dcrd_ring_cell.sv
// One entry of the recent-distance chain; shifts toward the older end on a push.
module dcrd_ring_cell #(
    parameter logic [dcrd_pkg::DIST_W-1:0] INIT_VALUE = '0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift_en,
    input  logic [dcrd_pkg::DIST_W-1:0]   shift_in,
    output logic [dcrd_pkg::DIST_W-1:0]   value
);
    import dcrd_pkg::*;

    logic [DIST_W-1:0] value_reg;
    logic [DIST_W-1:0] value_next;

    // Take the neighbor's entry when the chain moves.
    always_comb
    begin
        value_next = shift_en ? shift_in : value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= INIT_VALUE;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

FILE: hw/rtl/dcrd_resolve.sv
// Reads the selected ring entry, applies the adjustment and decides the push.
module dcrd_resolve (
    input  dcrd_pkg::front_t                                      front,
    input  logic [dcrd_pkg::RING_DEPTH-1:0][dcrd_pkg::DIST_W-1:0] ring,
    output logic [dcrd_pkg::DIST_W-1:0]                           distance,
    output logic [dcrd_pkg::BITS_W-1:0]                           bits,
    output dcrd_pkg::status_t                                     status,
    output logic                                                  push,
    output logic [dcrd_pkg::DIST_W-1:0]                           push_value
);
    import dcrd_pkg::*;

    logic [DIST_W-1:0] v;
    logic [DIST_W-1:0] amount_w;
    logic [DIST_W-1:0] adjusted;
    status_t           ring_status;

    // Adjusted ring value with its underflow and overflow checks.
    always_comb
    begin
        v           = ring[front.slot];
        amount_w    = {30'd0, front.amount};
        adjusted    = v;
        ring_status = ST_OK;
        case (front.adj)
            ADJ_SUB:
            begin
                adjusted = v - amount_w;
                if (!(v > amount_w))
                begin
                    ring_status = ST_UNDERFLOW;
                end
            end
            ADJ_ADD:
            begin
                adjusted = v + amount_w;
                if (!(v < (32'hFFFF_FFFF - amount_w)))
                begin
                    ring_status = ST_OVERFLOW;
                end
            end
            default: adjusted = v;
        endcase
    end

    // Ring codes take the adjusted value; the rest pass through.
    always_comb
    begin
        bits = front.bits;
        if (front.src == SRC_RING)
        begin
            status     = ring_status;
            distance   = (ring_status == ST_OK) ? adjusted : '0;
            push       = front.push && (ring_status == ST_OK);
            push_value = adjusted;
        end
        else
        begin
            status     = front.status;
            distance   = front.distance;
            push       = front.push;
            push_value = front.distance;
        end
    end

endmodule

FILE: hw/rtl/distance_code_ring_decoder.sv
// Top level of the distance code ring decoder: register port, pipeline and ring chain.
//
// Usage: each request on the s_ channel carries one distance code. s_tuser[0] is the
// operation (0 asks only for the extra bit count, 1 decodes the distance). The result
// leaves on the m_ channel: m_tdata holds the distance and the extra bit count, and
// m_tuser the status (ok, ring underflow, ring overflow, code out of range).
// One request is accepted per cycle, sustained, while the receiver keeps up. A result
// passes the first-stage and then the output register: the decode apart from the ring
// runs in the accepting cycle, and the second stage reads the recent-distance chain,
// adjusts and pushes back into the ring, which sets the rate at one per cycle.
// The APB-style port writes special_enable (0x0), direct_count (0x4) and postfix_bits
// (0x8); write them only while no request is in flight. A direct_count above 120 is
// ignored. Reset restores the registers to 1, 0, 0, the ring to 4, 11, 15, 16 and
// empties the pipeline. When the receiver stalls, the result holds in the output
// register and one more request is taken into the first stage; after that s_tready
// stays low until the output moves.
module distance_code_ring_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, from bit 0: distance_code[9:0], extra_value[33:10], zero fill to 40 bits.
    input  logic [39:0]                     s_tdata,
    // s_tuser, from bit 0: operation.
    input  logic [0:0]                      s_tuser,
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, from bit 0: distance[31:0], extra_bit_count[36:32], zero fill to 40 bits.
    output logic [39:0]                     m_tdata,
    // m_tuser, from bit 0: status[1:0].
    output logic [1:0]                      m_tuser,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dcrd_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import dcrd_pkg::*;

    logic                  special_enable_reg;
    logic [DIRECT_W-1:0]   direct_count_reg;
    logic [POSTFIX_W-1:0]  postfix_bits_reg;
    logic                  cfg_write;
    reg_index_t            reg_index;

    front_t                front;
    front_t                s1_reg;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DIST_W-1:0]     out_dist_reg;
    logic [BITS_W-1:0]     out_bits_reg;
    status_t               out_status_reg;

    logic                  out_en;
    logic                  in_fire;
    logic                  s1_fire;

    logic [DIST_W-1:0]     res_dist;
    logic [BITS_W-1:0]     res_bits;
    status_t               res_status;
    logic                  res_push;
    logic [DIST_W-1:0]     res_push_value;
    logic                  ring_shift;

    logic [RING_DEPTH-1:0][DIST_W-1:0] ring_q;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            special_enable_reg <= 1'b1;
            direct_count_reg   <= '0;
            postfix_bits_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_SPECIAL_ENABLE: special_enable_reg <= pwdata[0];
                REG_DIRECT_COUNT:
                begin
                    if (pwdata[DIRECT_W-1:0] <= MAX_DIRECT)
                    begin
                        direct_count_reg <= pwdata[DIRECT_W-1:0];
                    end
                end
                REG_POSTFIX_BITS:   postfix_bits_reg <= pwdata[POSTFIX_W-1:0];
                default:            special_enable_reg <= special_enable_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_index)
            REG_SPECIAL_ENABLE: prdata = {31'd0, special_enable_reg};
            REG_DIRECT_COUNT:   prdata = {25'd0, direct_count_reg};
            REG_POSTFIX_BITS:   prdata = {30'd0, postfix_bits_reg};
            default:            prdata = '0;
        endcase
    end

    // First stage: decode everything that does not need the ring.
    dcrd_front u_front (
        .special_enable (special_enable_reg),
        .direct_count   (direct_count_reg),
        .postfix_bits   (postfix_bits_reg),
        .operation      (s_tuser[0]),
        .distance_code  (s_tdata[9:0]),
        .extra_value    (s_tdata[33:10]),
        .front          (front)
    );

    // Pipeline flow control.
    assign out_en   = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_en;
    assign in_fire  = s_tvalid && s_tready;
    assign s1_fire  = s1_valid_reg && out_en;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg <= front;
        end
        if (s1_fire)
        begin
            out_dist_reg   <= res_dist;
            out_bits_reg   <= res_bits;
            out_status_reg <= res_status;
        end
    end

    // Second stage: ring read, adjustment and push decision.
    dcrd_resolve u_resolve (
        .front      (s1_reg),
        .ring       (ring_q),
        .distance   (res_dist),
        .bits       (res_bits),
        .status     (res_status),
        .push       (res_push),
        .push_value (res_push_value)
    );

    // Recent-distance chain: index 0 is the oldest entry, the top cell the newest.
    assign ring_shift = s1_fire && res_push;

    for (genvar i = 0; i < RING_DEPTH; i++)
    begin : g_ring
        logic [DIST_W-1:0] cell_in;
        if (i == RING_DEPTH - 1)
        begin : g_top
            assign cell_in = res_push_value;
        end
        else
        begin : g_mid
            assign cell_in = ring_q[i+1];
        end
        dcrd_ring_cell #(
            .INIT_VALUE (RING_INIT[i])
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (ring_shift),
            .shift_in (cell_in),
            .value    (ring_q[i])
        );
    end

    // Result channel.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_bits_reg, out_dist_reg};
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    // Any failing status carries a zero distance.
    a_error_zero_dist : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[31:0] == '0))
        else $error("nonzero distance with a failing status");

    // An out-of-range code reports no extra bits.
    a_range_zero_bits : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_RANGE)) |-> (m_tdata[36:32] == '0))
        else $error("extra bit count on an out-of-range code");

    // A push lands in the newest cell and moves the former newest entry down.
    a_push_shift : assert property (@(posedge clk) disable iff (!rst_n)
        ring_shift |=> ((ring_q[RING_DEPTH-1] == $past(res_push_value)) &&
                        (ring_q[RING_DEPTH-2] == $past(ring_q[RING_DEPTH-1]))))
        else $error("ring chain did not shift correctly on a push");
`endif

endmodule

FILE: dv/dcrd_checker.sv
// Scoreboard for the distance code ring decoder: predicts each result and checks the output.
package dcrd_tb_pkg;

    typedef enum logic {
        OP_QUERY  = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

endpackage

module dcrd_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // s_tdata, from bit 0: distance_code[9:0], extra_value[33:10], zero fill.
    input  logic [39:0]                   s_tdata,
    // s_tuser, from bit 0: operation.
    input  logic [0:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata, from bit 0: distance[31:0], extra_bit_count[36:32], zero fill.
    input  logic [39:0]                   m_tdata,
    // m_tuser, from bit 0: status[1:0].
    input  logic [1:0]                    m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcrd_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          pready,
    output int                            mismatch_count,
    output int                            results_owed
);
    import dcrd_pkg::*;
    import dcrd_tb_pkg::*;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [BITS_W-1:0] bit_count;
        status_t           status;
    } dist_result_t;

    // Shadow copy of the decoder's registers and recent-distance ring.
    logic                 brotli_mode;
    logic [DIRECT_W-1:0]  direct_cfg;
    logic [POSTFIX_W-1:0] postfix_cfg;
    logic [DIST_W-1:0]    recent_dist [RING_DEPTH];
    logic [SLOT_W-1:0]    ring_pos;

    dist_result_t expected_results [$];

    // Writes a distance into the slot at the current position and advances it.
    function automatic void ring_push(logic [DIST_W-1:0] value);
        recent_dist[ring_pos] = value;
        ring_pos = ring_pos + SLOT_W'(1);
    endfunction

    // Works out one result and updates the shadow ring the way the decoder does.
    function automatic dist_result_t decode_distance(op_t op, logic [CODE_W-1:0] code,
                                                     logic [EXTRA_W-1:0] extra);
        logic [31:0]       code_w;
        logic [31:0]       extra_w;
        logic [31:0]       direct_w;
        logic [31:0]       shift_w;
        logic [31:0]       special;
        logic [31:0]       direct_end;
        logic [31:0]       code_limit;
        logic [31:0]       nbits;
        logic [31:0]       x;
        logic [31:0]       high;
        logic [31:0]       low;
        logic [31:0]       offset;
        logic [DIST_W-1:0] v;
        logic [SLOT_W-1:0] k;
        logic [SLOT_W-1:0] rd_slot;
        dist_result_t      r;
        code_w     = 32'(code);
        extra_w    = 32'(extra);
        direct_w   = 32'(direct_cfg);
        shift_w    = 32'(postfix_cfg);
        special    = brotli_mode ? 32'd16 : 32'd0;
        direct_end = special + direct_w;
        code_limit = direct_end + (32'd48 << shift_w);
        nbits      = 32'd0;
        r.distance = '0;
        r.status   = ST_OK;
        if (code_w >= code_limit)
        begin
            r.status = ST_RANGE;
        end
        else
        begin
            if (code_w >= direct_end)
                nbits = 32'd1 + ((code_w - direct_end) >> (shift_w + 32'd1));
            if (op == OP_DECODE)
            begin
                if (code_w < special)
                begin
                    // Ring reference, possibly adjusted by one, two or three.
                    k = 2'd0;
                    if (code_w == 32'd1 || code_w >= 32'd10)
                        k = 2'd1;
                    else if (code_w == 32'd2)
                        k = 2'd2;
                    else if (code_w == 32'd3)
                        k = 2'd3;
                    rd_slot = ring_pos + k;
                    v = recent_dist[rd_slot];
                    case (code_w)
                        32'd4, 32'd10:
                        begin
                            if (v > 32'd1)
                                v = v - 32'd1;
                            else
                                r.status = ST_UNDERFLOW;
                        end
                        32'd5, 32'd11:
                        begin
                            if (v < 32'hFFFF_FFFE)
                                v = v + 32'd1;
                            else
                                r.status = ST_OVERFLOW;
                        end
                        32'd6, 32'd12:
                        begin
                            if (v > 32'd2)
                                v = v - 32'd2;
                            else
                                r.status = ST_UNDERFLOW;
                        end
                        32'd7, 32'd13:
                        begin
                            if (v < 32'hFFFF_FFFD)
                                v = v + 32'd2;
                            else
                                r.status = ST_OVERFLOW;
                        end
                        32'd8, 32'd14:
                        begin
                            if (v > 32'd3)
                                v = v - 32'd3;
                            else
                                r.status = ST_UNDERFLOW;
                        end
                        32'd9, 32'd15:
                        begin
                            if (v < 32'hFFFF_FFFC)
                                v = v + 32'd3;
                            else
                                r.status = ST_OVERFLOW;
                        end
                        default: ;
                    endcase
                    if (r.status == ST_OK)
                    begin
                        r.distance = v;
                        if (code_w != 32'd0)
                            ring_push(v);
                    end
                end
                else if (code_w < direct_end)
                begin
                    r.distance = code_w - special + 32'd1;
                end
                else
                begin
                    // Postfix and offset arithmetic; only Brotli mode remembers it.
                    x      = code_w - direct_end;
                    high   = x >> shift_w;
                    low    = x & ((32'd1 << shift_w) - 32'd1);
                    offset = ((32'd2 | (high & 32'd1)) << nbits) - 32'd4;
                    if (brotli_mode)
                    begin
                        r.distance = ((offset + extra_w) << shift_w) + low
                                   + direct_w + 32'd1;
                        ring_push(r.distance);
                    end
                    else
                    begin
                        r.distance = ((offset + low) << shift_w) + extra_w
                                   + direct_w + 32'd1;
                    end
                end
            end
        end
        r.bit_count = nbits[BITS_W-1:0];
        return r;
    endfunction

    // Follows register writes, requests and results at every clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        dist_result_t want;
        if (!rst_n)
        begin
            brotli_mode = 1'b1;
            direct_cfg  = '0;
            postfix_cfg = '0;
            for (int i = 0; i < RING_DEPTH; i++)
                recent_dist[i] = RING_INIT[i];
            ring_pos = '0;
            expected_results.delete();
            mismatch_count <= 0;
            results_owed   <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[3:2]))
                    REG_SPECIAL_ENABLE: brotli_mode = pwdata[0];
                    REG_DIRECT_COUNT:
                    begin
                        if (pwdata[DIRECT_W-1:0] <= MAX_DIRECT)
                            direct_cfg = pwdata[DIRECT_W-1:0];
                    end
                    REG_POSTFIX_BITS:   postfix_cfg = pwdata[POSTFIX_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request waiting: distance %0h", m_tdata[31:0]);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.distance || m_tdata[36:32] !== want.bit_count
                        || m_tuser !== want.status)
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (m_tdata[31:0] !== want.distance)
                            $error("distance: expected %0h, got %0h",
                                   want.distance, m_tdata[31:0]);
                        if (m_tdata[36:32] !== want.bit_count)
                            $error("extra_bit_count: expected %0d, got %0d",
                                   want.bit_count, m_tdata[36:32]);
                        if (m_tuser !== want.status)
                            $error("status: expected %0d, got %0d", want.status, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(decode_distance(op_t'(s_tuser[0]), s_tdata[9:0],
                                                           s_tdata[33:10]));
            results_owed <= expected_results.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// Top of the distance code ring decoder testbench: clock, reset, stimulus and verdict.
module testbench;

    import dcrd_pkg::*;
    import dcrd_tb_pkg::*;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [39:0]         s_tdata = '0;
    logic [0:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [39:0]         m_tdata;
    logic [1:0]          m_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    int mismatch_count;
    int results_owed;

    // Idling odds in percent, and the request for one long receiver hold-off.
    int   send_idle = 0;
    int   sink_stall = 0;
    logic long_hold_req = 1'b0;

    // Register values as last written, used to aim the codes.
    logic                 cfg_brotli = 1'b1;
    int unsigned          cfg_direct = 0;
    int unsigned          cfg_postfix = 0;

    distance_code_ring_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dcrd_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    initial
    begin
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req != hold_seen)
            begin
                hold_seen = long_hold_req;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= sink_stall);
            end
        end
    end

    // Offers one request and returns at the edge that takes it.
    task automatic send_req(input op_t op, input logic [CODE_W-1:0] code,
                            input logic [EXTRA_W-1:0] extra);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, extra, code};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
    endtask

    // Stops offering and waits until every result owed has left.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // Setup and access cycles of one register write; the bus is released by the caller.
    task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // Writes all three registers, with an out-of-range direct count that must be ignored.
    task automatic set_config(input logic brotli, input int unsigned direct,
                              input int unsigned postfix);
        apb_write(REG_SPECIAL_ENABLE, {31'($urandom), brotli});
        apb_write(REG_DIRECT_COUNT, {25'($urandom), 7'(direct)});
        apb_write(REG_DIRECT_COUNT, {25'd0, 7'($urandom_range(127, 121))});
        apb_write(REG_POSTFIX_BITS, {30'($urandom), 2'(postfix)});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        cfg_brotli  = brotli;
        cfg_direct  = direct;
        cfg_postfix = postfix;
    endtask

    // Random codes spread over ring, direct, postfix and out-of-range regions.
    task automatic send_random(input int count);
        int unsigned   direct_end;
        int unsigned   span;
        int unsigned   pick;
        int unsigned   nbits;
        int unsigned   code;
        logic [23:0]   extra;
        op_t           op;
        for (int n = 0; n < count; n++)
        begin
            direct_end = (cfg_brotli ? 16 : 0) + cfg_direct;
            span       = 48 << cfg_postfix;
            pick       = $urandom_range(99);
            if (pick < 30 && cfg_brotli)
                code = $urandom_range(15);
            else if (pick < 42 && cfg_direct != 0)
                code = direct_end - cfg_direct + $urandom_range(cfg_direct - 1);
            else if (pick < 88)
                code = direct_end + $urandom_range(span - 1);
            else if (pick < 96)
                code = $urandom_range(1023, direct_end + span);
            else
                code = $urandom_range(1023);
            case ($urandom_range(3))
                0, 1: extra = 24'($urandom);
                2:    extra = 24'($urandom_range(3));
                default:
                begin
                    nbits = (code >= direct_end)
                          ? 1 + ((code - direct_end) >> (cfg_postfix + 1)) : 0;
                    extra = 24'($urandom & ((32'd1 << nbits) - 1));
                end
            endcase
            op = ($urandom_range(99) < 85) ? OP_DECODE : OP_QUERY;
            send_req(op, 10'(code), extra);
        end
    endtask

    // Run limit.
    initial
    begin
        #400000;
        $display("[distance_code_ring_decoder] ERROR");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int   p_brotli;
        int   p_direct;
        int   p_postfix;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings: every ring code first.
        for (int c = 0; c < 16; c++)
            send_req(OP_DECODE, 10'(c), 24'($urandom));
        // Fill the ring with ones so that downward adjustments underflow.
        repeat (4) send_req(OP_DECODE, 10'd16, 24'd0);
        send_req(OP_DECODE, 10'd4, 24'd0);
        send_req(OP_DECODE, 10'd10, 24'hFFFFFF);
        send_req(OP_DECODE, 10'd14, 24'd0);
        send_req(OP_DECODE, 10'd5, 24'd0);
        // Last valid postfix code, the first code past the range, and the largest code.
        send_req(OP_QUERY, 10'd63, 24'd0);
        send_req(OP_DECODE, 10'd63, 24'hFFFFFF);
        send_req(OP_QUERY, 10'd64, 24'hFFFFFF);
        send_req(OP_DECODE, 10'd1023, 24'hFFFFFF);

        // Random phases through several register settings and idling mixes.
        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    p_brotli = 1;
                    p_direct = 0;
                    p_postfix = 0;
                end
                1:
                begin
                    p_brotli = 1;
                    p_direct = 120;
                    p_postfix = 3;
                end
                2:
                begin
                    p_brotli = 0;
                    p_direct = 0;
                    p_postfix = 0;
                end
                3:
                begin
                    p_brotli = 0;
                    p_direct = 120;
                    p_postfix = 3;
                end
                4:
                begin
                    p_brotli = 1;
                    p_direct = 37;
                    p_postfix = 2;
                end
                5:
                begin
                    p_brotli = 0;
                    p_direct = 5;
                    p_postfix = 1;
                end
                default:
                begin
                    p_brotli  = $urandom_range(1);
                    p_direct  = $urandom_range(120);
                    p_postfix = $urandom_range(3);
                end
            endcase
            set_config(1'(p_brotli), p_direct, p_postfix);
            case (p % 4)
                0:
                begin
                    send_idle = 0;
                    sink_stall = 0;
                end
                1:
                begin
                    send_idle = 51;
                    sink_stall = 0;
                end
                2:
                begin
                    send_idle = 0;
                    sink_stall = 51;
                end
                default:
                begin
                    send_idle = 29;
                    sink_stall = 29;
                end
            endcase
            if (p == 0)
            begin
                // Long receiver hold-off while requests keep coming, then a full pause.
                send_random(30);
                long_hold_req = ~long_hold_req;
                send_random(40);
                wait_drained();
                send_random(70);
            end
            else
            begin
                send_random(140);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("[distance_code_ring_decoder] OK");
        else
            $display("[distance_code_ring_decoder] ERROR");
        $finish;
    end

endmodule
